// ----- rtl/sao_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sao_pkg
// shared types and constants for the sprite alpha overlay core
// ----------------------------------------------------------------------------
package sao_pkg;

    // default sprite store geometry
    localparam int MAX_SPRITE_WIDTH_DEF  = 128;
    localparam int MAX_SPRITE_HEIGHT_DEF = 128;

    // frame dimension limit
    localparam int MAX_FRAME_DIM = 4096;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 3'd5;

    // register reset values
    localparam logic [11:0] CENTER_X_RST      = 12'd0;
    localparam logic [11:0] CENTER_Y_RST      = 12'd0;
    localparam logic [7:0]  SPRITE_WIDTH_RST  = 8'd64;
    localparam logic [7:0]  SPRITE_HEIGHT_RST = 8'd64;
    localparam logic [12:0] FRAME_WIDTH_RST   = 13'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST  = 13'd480;

    // stream widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    localparam logic [7:0] OPAQUE = 8'd255;

    typedef enum logic
    {
        CMD_LOAD      = 1'b0,
        CMD_COMPOSITE = 1'b1
    } sao_cmd_t;

    // one classified item as it travels through the queue
    typedef struct packed
    {
        sao_cmd_t   cmd;
        logic       load_ok;
        logic       blend_sel;
        logic       rejected;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } sao_item_t;

endpackage
`default_nettype wire

// ----- rtl/sao_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sao_queue
// small first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
module sao_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // no overflow, no underflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- rtl/sao_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sao_front
// configuration registers, placement test and classification of input items
// ----------------------------------------------------------------------------
module sao_front
    import sao_pkg::*;
#(
    parameter int MAX_SPRITE_WIDTH  = MAX_SPRITE_WIDTH_DEF,
    parameter int MAX_SPRITE_HEIGHT = MAX_SPRITE_HEIGHT_DEF,
    parameter int AW                = 14
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   queue_full,
    output logic                        push,
    output sao_item_t                   item,
    output logic [AW-1:0]               item_addr
);

    localparam int XW = (MAX_SPRITE_WIDTH > 1) ? $clog2(MAX_SPRITE_WIDTH) : 1;
    localparam int YW = (MAX_SPRITE_HEIGHT > 1) ? $clog2(MAX_SPRITE_HEIGHT) : 1;

    logic [11:0] center_x_reg;
    logic [11:0] center_y_reg;
    logic [7:0]  sprite_width_reg;
    logic [7:0]  sprite_height_reg;
    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic        cfg_settle_reg;

    // derived placement values
    logic [7:0]         w_sat;
    logic [7:0]         h_sat;
    logic [12:0]        fw_sat;
    logic [12:0]        fh_sat;
    logic signed [14:0] hw;
    logic signed [14:0] hh;
    logic signed [14:0] lx;
    logic signed [14:0] ly;
    logic signed [14:0] fw_s;
    logic signed [14:0] fh_s;
    logic               rej;

    logic [7:0]         w_reg;
    logic [7:0]         h_reg;
    logic [12:0]        fw_reg;
    logic [12:0]        fh_reg;
    logic signed [14:0] lx_reg;
    logic signed [14:0] ly_reg;
    logic               rej_reg;

    // item fields
    logic [11:0]        px;
    logic [11:0]        py;
    logic signed [14:0] fx;
    logic signed [14:0] fy;
    logic               in_frame;
    logic               in_win;
    logic               load_ok;
    logic [XW-1:0]      ax;
    logic [YW-1:0]      ay;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= CENTER_X_RST;
            center_y_reg      <= CENTER_Y_RST;
            sprite_width_reg  <= SPRITE_WIDTH_RST;
            sprite_height_reg <= SPRITE_HEIGHT_RST;
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            cfg_settle_reg    <= 1'b1;
        end
        else
        begin
            cfg_settle_reg <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CENTER_X:      center_x_reg      <= cfg_data[11:0];
                    CFG_CENTER_Y:      center_y_reg      <= cfg_data[11:0];
                    CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[7:0];
                    CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[7:0];
                    CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                    CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        w_sat  = (32'(sprite_width_reg) > MAX_SPRITE_WIDTH)
                 ? 8'(MAX_SPRITE_WIDTH) : sprite_width_reg;
        h_sat  = (32'(sprite_height_reg) > MAX_SPRITE_HEIGHT)
                 ? 8'(MAX_SPRITE_HEIGHT) : sprite_height_reg;
        fw_sat = (32'(frame_width_reg) > MAX_FRAME_DIM)
                 ? 13'(MAX_FRAME_DIM) : frame_width_reg;
        fh_sat = (32'(frame_height_reg) > MAX_FRAME_DIM)
                 ? 13'(MAX_FRAME_DIM) : frame_height_reg;
        hw     = $signed({8'b0, w_sat[7:1]});
        hh     = $signed({8'b0, h_sat[7:1]});
        lx     = $signed({3'b0, center_x_reg}) - hw;
        ly     = $signed({3'b0, center_y_reg}) - hh;
        fw_s   = $signed({2'b0, fw_sat});
        fh_s   = $signed({2'b0, fh_sat});
        rej    = lx[14] || ly[14]
                 || (lx - hw - 15'sd1 <= 15'sd0) || (ly - hh - 15'sd1 <= 15'sd0)
                 || (lx + hw + 15'sd1 >= fw_s) || (ly + hh + 15'sd1 >= fh_s);
    end

    // placement registered every cycle from the current configuration
    always_ff @(posedge clk)
    begin
        w_reg   <= w_sat;
        h_reg   <= h_sat;
        fw_reg  <= fw_sat;
        fh_reg  <= fh_sat;
        lx_reg  <= lx;
        ly_reg  <= ly;
        rej_reg <= rej;
    end

    always_comb
    begin
        px       = s_tdata[11:0];
        py       = s_tdata[23:12];
        fx       = $signed({3'b0, px}) - lx_reg;
        fy       = $signed({3'b0, py}) - ly_reg;
        in_frame = ({1'b0, px} < fw_reg) && ({1'b0, py} < fh_reg);
        in_win   = !fx[14] && (fx < $signed({7'b0, w_reg}))
                   && !fy[14] && (fy < $signed({7'b0, h_reg}));
        load_ok  = (32'(px) < MAX_SPRITE_WIDTH) && (32'(py) < MAX_SPRITE_HEIGHT);

        item.cmd       = sao_cmd_t'(s_tuser);
        item.load_ok   = load_ok;
        item.blend_sel = !rej_reg && in_frame && in_win;
        item.rejected  = rej_reg;
        item.blue      = s_tdata[31:24];
        item.green     = s_tdata[39:32];
        item.red       = s_tdata[47:40];
        item.alpha     = s_tdata[55:48];

        if (item.cmd == CMD_LOAD)
        begin
            ax = px[XW-1:0];
            ay = py[YW-1:0];
        end
        else
        begin
            ax = fx[XW-1:0];
            ay = fy[YW-1:0];
        end
        item_addr = AW'(ay) * AW'(MAX_SPRITE_WIDTH) + AW'(ax);
    end

    assign s_tready = !queue_full && !cfg_settle_reg;
    assign push     = s_tvalid && s_tready;

    // placement values are stale until the registered placement follows a register write
    a_settle_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_settle_reg |-> !push)
        else $error("item taken while placement settles");

endmodule
`default_nettype wire

// ----- rtl/sao_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sao_back
// sprite store, alpha blend pipeline and output register
// ----------------------------------------------------------------------------
module sao_back
    import sao_pkg::*;
#(
    parameter int MAX_SPRITE_WIDTH  = MAX_SPRITE_WIDTH_DEF,
    parameter int MAX_SPRITE_HEIGHT = MAX_SPRITE_HEIGHT_DEF,
    parameter int AW                = 14
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  queue_empty,
    input  wire sao_item_t             head,
    input  wire logic [AW-1:0]         head_addr,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser
);

    localparam int SPRITE_DEPTH = MAX_SPRITE_WIDTH * MAX_SPRITE_HEIGHT;

    logic [31:0] sprite_mem [SPRITE_DEPTH];
    logic [31:0] rd_data_reg;

    logic        adv;

    // stage one: store read
    logic        s1_valid_reg;
    logic        s1_blend_reg;
    logic        s1_rej_reg;
    logic [7:0]  s1_b_reg;
    logic [7:0]  s1_g_reg;
    logic [7:0]  s1_r_reg;

    // stage two: weighted sums
    logic [7:0]  sa_eff;
    logic [7:0]  sa_inv;
    logic [7:0]  fg_b;
    logic [7:0]  fg_g;
    logic [7:0]  fg_r;
    logic        s2_valid_reg;
    logic        s2_rej_reg;
    logic [15:0] s2_b_reg;
    logic [15:0] s2_g_reg;
    logic [15:0] s2_r_reg;

    // output stage
    logic [15:0] tb;
    logic [15:0] tg;
    logic [15:0] tr;
    logic        out_valid_reg;
    logic        out_rej_reg;
    logic [7:0]  out_b_reg;
    logic [7:0]  out_g_reg;
    logic [7:0]  out_r_reg;

    assign adv = !(out_valid_reg && !m_tready);
    assign pop = !queue_empty && adv;

    always_ff @(posedge clk)
    begin
        if (pop && head.cmd == CMD_LOAD && head.load_ok)
        begin
            sprite_mem[head_addr] <= {head.alpha, head.red, head.green, head.blue};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.cmd == CMD_COMPOSITE)
        begin
            rd_data_reg <= sprite_mem[head_addr];
        end
    end

    always_comb
    begin
        // store word only used inside the window
        sa_eff = s1_blend_reg ? rd_data_reg[31:24] : 8'd0;
        fg_b   = s1_blend_reg ? rd_data_reg[7:0] : 8'd0;
        fg_g   = s1_blend_reg ? rd_data_reg[15:8] : 8'd0;
        fg_r   = s1_blend_reg ? rd_data_reg[23:16] : 8'd0;
        sa_inv = OPAQUE - sa_eff;
        // division by 255 of a sum not above 255*255
        tb     = s2_b_reg + 16'd1 + {8'b0, s2_b_reg[15:8]};
        tg     = s2_g_reg + 16'd1 + {8'b0, s2_g_reg[15:8]};
        tr     = s2_r_reg + 16'd1 + {8'b0, s2_r_reg[15:8]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop && head.cmd == CMD_COMPOSITE;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_blend_reg <= head.blend_sel;
            s1_rej_reg   <= head.rejected;
            s1_b_reg     <= head.blue;
            s1_g_reg     <= head.green;
            s1_r_reg     <= head.red;

            s2_rej_reg   <= s1_rej_reg;
            s2_b_reg     <= 16'(s1_b_reg) * 16'(sa_inv) + 16'(fg_b) * 16'(sa_eff);
            s2_g_reg     <= 16'(s1_g_reg) * 16'(sa_inv) + 16'(fg_g) * 16'(sa_eff);
            s2_r_reg     <= 16'(s1_r_reg) * 16'(sa_inv) + 16'(fg_r) * 16'(sa_eff);

            out_rej_reg  <= s2_rej_reg;
            out_b_reg    <= tb[15:8];
            out_g_reg    <= tg[15:8];
            out_r_reg    <= tr[15:8];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_r_reg, out_g_reg, out_b_reg};
    assign m_tuser  = out_rej_reg;

endmodule
`default_nettype wire

// ----- rtl/sprite_alpha_overlay_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_alpha_overlay_core
// blends a stored bgra sprite over a stream of bgr background pixels
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side accepts: load items write
// a sprite pixel into a single-port store, background items each give one
// result through the store read, the weighted sums and the divide by 255
// into the output register. The store does one access per cycle,
// which sets the rate of one item per clock. A four-entry queue separates
// the classifying front from the blending back, so input and output stall
// independently. After reset and after every register write, input is held
// off while the placement test is recomputed. The sprite store has no reset;
// every entry must be loaded before it is blended.
// ----------------------------------------------------------------------------
module sprite_alpha_overlay_core
    import sao_pkg::*;
#(
    parameter int MAX_SPRITE_WIDTH  = MAX_SPRITE_WIDTH_DEF,
    parameter int MAX_SPRITE_HEIGHT = MAX_SPRITE_HEIGHT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,  // pos_x, pos_y, blue, green, red, alpha
    input  wire logic                   s_tuser,  // command
    // output stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,  // out_blue, out_green, out_red
    output logic                        m_tuser   // placement_rejected
);

    localparam int SPRITE_DEPTH = MAX_SPRITE_WIDTH * MAX_SPRITE_HEIGHT;
    localparam int AW           = (SPRITE_DEPTH > 1) ? $clog2(SPRITE_DEPTH) : 1;
    localparam int QW           = $bits(sao_item_t) + AW;

    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;
    sao_item_t       item;
    logic [AW-1:0]   item_addr;
    logic [QW-1:0]   head_word;
    sao_item_t       head;
    logic [AW-1:0]   head_addr;

    sao_front
    #(
        .MAX_SPRITE_WIDTH  (MAX_SPRITE_WIDTH),
        .MAX_SPRITE_HEIGHT (MAX_SPRITE_HEIGHT),
        .AW                (AW)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .item       (item),
        .item_addr  (item_addr)
    );

    sao_queue
    #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({item_addr, item}),
        .full    (queue_full),
        .rd_en   (pop),
        .rd_data (head_word),
        .empty   (queue_empty)
    );

    assign head      = sao_item_t'(head_word[$bits(sao_item_t)-1:0]);
    assign head_addr = head_word[QW-1:$bits(sao_item_t)];

    sao_back
    #(
        .MAX_SPRITE_WIDTH  (MAX_SPRITE_WIDTH),
        .MAX_SPRITE_HEIGHT (MAX_SPRITE_HEIGHT),
        .AW                (AW)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .head_addr   (head_addr),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire

// ----- test/sprite_alpha_overlay_checker.sv -----
// ----------------------------------------------------------------------------
// sprite_alpha_overlay_checker
// watches the configuration, input and output channels of the overlay core,
// keeps its own copy of the registers and the sprite store, works out the
// composited pixel for every background transaction and compares each output
// transaction with the oldest pending pixel
// ----------------------------------------------------------------------------
module sprite_alpha_overlay_checker
    import sao_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,  // pos_x, pos_y, blue, green, red, alpha
    input  logic                   s_tuser,  // command
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,  // out_blue, out_green, out_red
    input  logic                   m_tuser,  // placement_rejected
    output int                     mismatches,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       rejected;
    } pixel_t;

    localparam int STORE_DEPTH = MAX_SPRITE_WIDTH_DEF * MAX_SPRITE_HEIGHT_DEF;

    logic [31:0] sprite_mem [STORE_DEPTH];
    logic [11:0] centre_x;
    logic [11:0] centre_y;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [12:0] fwidth_reg;
    logic [12:0] fheight_reg;
    pixel_t      expected_pixels [$];

    function automatic logic [7:0] mix_channel(input int bg, input int fg, input int a);
        int sum;
        sum = (bg * (int'(OPAQUE) - a) + fg * a) / int'(OPAQUE);
        return sum[7:0];
    endfunction

    function automatic pixel_t composite_pixel(input logic [11:0] px, input logic [11:0] py,
                                               input logic [7:0] b, input logic [7:0] g,
                                               input logic [7:0] r);
        int          w;
        int          h;
        int          fw;
        int          fh;
        int          lx;
        int          ly;
        int          fx;
        int          fy;
        int          a;
        logic [31:0] word;
        pixel_t      p;
        w  = (int'(width_reg) > MAX_SPRITE_WIDTH_DEF) ? MAX_SPRITE_WIDTH_DEF : int'(width_reg);
        h  = (int'(height_reg) > MAX_SPRITE_HEIGHT_DEF) ? MAX_SPRITE_HEIGHT_DEF
                                                        : int'(height_reg);
        fw = (int'(fwidth_reg) > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(fwidth_reg);
        fh = (int'(fheight_reg) > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(fheight_reg);
        lx = int'(centre_x) - w / 2;
        ly = int'(centre_y) - h / 2;
        p.rejected = (lx < 0) || (ly < 0) || (lx - w / 2 - 1 <= 0) || (ly - h / 2 - 1 <= 0) ||
                     (lx + w / 2 + 1 >= fw) || (ly + h / 2 + 1 >= fh);
        p.blue  = b;
        p.green = g;
        p.red   = r;
        if (!p.rejected && int'(px) < fw && int'(py) < fh)
        begin
            fx = int'(px) - lx;
            fy = int'(py) - ly;
            if (fx >= 0 && fx < w && fy >= 0 && fy < h)
            begin
                word = sprite_mem[fy * MAX_SPRITE_WIDTH_DEF + fx];
                a    = int'(word[31:24]);
                if (a > 0)
                begin
                    p.blue  = mix_channel(int'(b), int'(word[7:0]), a);
                    p.green = mix_channel(int'(g), int'(word[15:8]), a);
                    p.red   = mix_channel(int'(r), int'(word[23:16]), a);
                end
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            centre_x    = CENTER_X_RST;
            centre_y    = CENTER_Y_RST;
            width_reg   = SPRITE_WIDTH_RST;
            height_reg  = SPRITE_HEIGHT_RST;
            fwidth_reg  = FRAME_WIDTH_RST;
            fheight_reg = FRAME_HEIGHT_RST;
            expected_pixels.delete();
            mismatches  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CENTER_X:      centre_x    = cfg_data[11:0];
                    CFG_CENTER_Y:      centre_y    = cfg_data[11:0];
                    CFG_SPRITE_WIDTH:  width_reg   = cfg_data[7:0];
                    CFG_SPRITE_HEIGHT: height_reg  = cfg_data[7:0];
                    CFG_FRAME_WIDTH:   fwidth_reg  = cfg_data[12:0];
                    CFG_FRAME_HEIGHT:  fheight_reg = cfg_data[12:0];
                    default:           ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser};
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: output transaction with nothing pending, expected none, ",
                             $time, "actual b=%02h g=%02h r=%02h rej=%0b",
                             got.blue, got.green, got.red, got.rejected);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: pixel mismatch, expected b=%02h g=%02h r=%02h rej=%0b, ",
                                 $time, want.blue, want.green, want.red, want.rejected,
                                 "actual b=%02h g=%02h r=%02h rej=%0b",
                                 got.blue, got.green, got.red, got.rejected);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_LOAD)
                begin
                    if (int'(s_tdata[11:0]) < MAX_SPRITE_WIDTH_DEF &&
                        int'(s_tdata[23:12]) < MAX_SPRITE_HEIGHT_DEF)
                        sprite_mem[int'(s_tdata[23:12]) * MAX_SPRITE_WIDTH_DEF +
                                   int'(s_tdata[11:0])] = s_tdata[55:24];
                end
                else
                    expected_pixels.push_back(composite_pixel(s_tdata[11:0], s_tdata[23:12],
                                                              s_tdata[31:24], s_tdata[39:32],
                                                              s_tdata[47:40]));
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ----- test/sprite_alpha_overlay_core_tb.sv -----
// ----------------------------------------------------------------------------
// sprite_alpha_overlay_core_tb
// drives sprite loads, background pixels and register writes into the overlay
// core under several idle and stall mixes; a separate checker predicts and
// compares every output transaction and reports the failure count
// ----------------------------------------------------------------------------
module sprite_alpha_overlay_core_tb;
    import sao_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPRITE_W = MAX_SPRITE_WIDTH_DEF;
    localparam int SPRITE_H = MAX_SPRITE_HEIGHT_DEF;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = CFG_FRAME_HEIGHT + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    int                     mismatches;
    int                     pending_pixels;

    int cur_lx;
    int cur_ly;
    int cur_w;
    int cur_h;
    bit cur_ok;
    bit loaded [SPRITE_W*SPRITE_H];
    int window_hits [$];
    int send_idle_pct;
    int recv_stall_pct;

    sprite_alpha_overlay_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sprite_alpha_overlay_checker pixel_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_item(input sao_cmd_t cmd, input logic [11:0] px, input logic [11:0] py,
                             input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                             input logic [7:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {a, r, g, b, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_pixel(input logic [11:0] x, input logic [11:0] y, input logic [7:0] a);
        send_item(CMD_LOAD, x, y, 8'($urandom), 8'($urandom), 8'($urandom), a);
        if (int'(x) < SPRITE_W && int'(y) < SPRITE_H)
        begin
            loaded[int'(y) * SPRITE_W + int'(x)] = 1'b1;
            if (int'(x) < cur_w && int'(y) < cur_h)
                window_hits.push_back(int'(y) * SPRITE_W + int'(x));
        end
    endtask

    // never blend over a store entry that has not been loaded
    task automatic send_composite(input int px, input int py, input logic [7:0] b,
                                  input logic [7:0] g, input logic [7:0] r);
        logic [11:0] x;
        logic [11:0] y;
        int          fx;
        int          fy;
        x  = px[11:0];
        y  = py[11:0];
        fx = int'(x) - cur_lx;
        fy = int'(y) - cur_ly;
        if (cur_ok && fx >= 0 && fx < cur_w && fy >= 0 && fy < cur_h &&
            !loaded[fy * SPRITE_W + fx])
            x = 12'(cur_lx - 1);
        send_item(CMD_COMPOSITE, x, y, b, g, r, 8'($urandom));
    endtask

    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        while (pending_pixels != 0)
            @(negedge clk);
        repeat (settle)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [12:0] cx, input logic [12:0] cy,
                                input logic [12:0] sw, input logic [12:0] sh,
                                input logic [12:0] fw, input logic [12:0] fh, input bit spare);
        int fwe;
        int fhe;
        drain(16);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_SPRITE_WIDTH, sw);
        write_reg(CFG_SPRITE_HEIGHT, sh);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        if (spare)
        begin
            write_reg(CFG_SPARE_LOW, CFG_DATA_W'($urandom));
            write_reg(CFG_SPARE_HIGH, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        cur_w  = (int'(sw[7:0]) > SPRITE_W) ? SPRITE_W : int'(sw[7:0]);
        cur_h  = (int'(sh[7:0]) > SPRITE_H) ? SPRITE_H : int'(sh[7:0]);
        fwe    = (int'(fw) > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(fw);
        fhe    = (int'(fh) > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(fh);
        cur_lx = int'(cx[11:0]) - cur_w / 2;
        cur_ly = int'(cy[11:0]) - cur_h / 2;
        cur_ok = !(cur_lx < 0 || cur_ly < 0 || cur_lx - cur_w / 2 - 1 <= 0 ||
                   cur_ly - cur_h / 2 - 1 <= 0 || cur_lx + cur_w / 2 + 1 >= fwe ||
                   cur_ly + cur_h / 2 + 1 >= fhe);
        window_hits.delete();
    endtask

    function automatic logic [12:0] pick_dim();
        logic [12:0] v;
        int          r;
        v = 13'($urandom);
        r = $urandom_range(99);
        if (r < 70)
            v[7:0] = 8'($urandom_range(1, 12));
        else if (r < 80)
            v[7:0] = 8'd0;
        else if (r < 90)
            v[7:0] = 8'($urandom_range(128, 255));
        return v;
    endfunction

    function automatic logic [12:0] pick_frame();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return 13'(MAX_FRAME_DIM);
        else if (r < 35)
            return 13'($urandom_range(MAX_FRAME_DIM + 1, 8191));
        return 13'($urandom_range(64, MAX_FRAME_DIM));
    endfunction

    // mostly a centre that passes placement, often hugging either limit
    function automatic logic [12:0] pick_centre(input int size, input logic [12:0] frame);
        logic [12:0] v;
        int          lo;
        int          hi;
        int          r;
        v  = 13'($urandom);
        lo = 2 * (size / 2) + 2;
        hi = ((int'(frame) > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(frame)) - 2;
        r  = $urandom_range(99);
        if (hi >= lo && r < 85)
        begin
            if (r < 20)
                v[11:0] = 12'(lo);
            else if (r < 40)
                v[11:0] = 12'(hi);
            else
                v[11:0] = 12'($urandom_range(lo, hi));
        end
        return v;
    endfunction

    initial
    begin
        int          ph;
        int          i;
        int          r;
        int          we;
        int          he;
        int          fx;
        int          fy;
        int          idx;
        logic [12:0] sw;
        logic [12:0] sh;
        logic [12:0] fw;
        logic [12:0] fh;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_w          = int'(SPRITE_WIDTH_RST);
        cur_h          = int'(SPRITE_HEIGHT_RST);
        cur_lx         = int'(CENTER_X_RST) - cur_w / 2;
        cur_ly         = int'(CENTER_Y_RST) - cur_h / 2;
        cur_ok         = 1'b0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry fails placement
        send_composite(0, 0, 8'h00, 8'h00, 8'h00);
        send_composite(4095, 4095, 8'hFF, 8'hFF, 8'hFF);

        // window at 68..131 crossing the right frame edge
        apply_config(13'd100, 13'd100, 13'd64, 13'd64, 13'd110, 13'd480, 1'b1);
        load_pixel(12'd0, 12'd0, 8'h00);
        load_pixel(12'd1, 12'd0, 8'hFF);
        load_pixel(12'd2, 12'd0, 8'h80);
        load_pixel(12'd52, 12'd0, 8'h4D);
        load_pixel(12'd63, 12'd63, 8'h01);
        load_pixel(12'd127, 12'd127, 8'hFF);
        load_pixel(12'd128, 12'd0, 8'hFF);
        load_pixel(12'd0, 12'd128, 8'hFF);
        load_pixel(12'd4095, 12'd4095, 8'hFF);
        send_composite(68, 68, 8'hFF, 8'hFF, 8'hFF);
        send_composite(69, 68, 8'h00, 8'h00, 8'h00);
        send_composite(70, 68, 8'hFF, 8'hFF, 8'hFF);
        send_composite(70, 68, 8'h00, 8'h00, 8'h00);
        send_composite(120, 68, 8'h12, 8'h34, 8'h56);
        send_composite(67, 68, 8'hA5, 8'h5A, 8'hC3);
        send_composite(131, 131, 8'h3C, 8'hC3, 8'h99);

        // empty sprite window
        apply_config(13'd100, 13'd100, 13'd0, 13'd0, 13'd640, 13'd480, 1'b0);
        send_composite(100, 100, 8'hAA, 8'h55, 8'hAA);

        // top centre, oversized sprite and frame width, zero frame height
        apply_config(13'h1FFF, 13'h1FFF, 13'd200, 13'd255, 13'd8191, 13'd0, 1'b0);
        send_composite(0, 0, 8'h01, 8'h80, 8'hFE);
        send_composite(4095, 4095, 8'h7F, 8'hFF, 8'h00);

        for (ph = 0; ph < 10; ph++)
        begin
            sw = pick_dim();
            sh = pick_dim();
            fw = pick_frame();
            fh = pick_frame();
            if (ph == 3)
            begin
                sw = 13'd255;
                sh = 13'd128;
                fw = 13'd8191;
                fh = 13'(MAX_FRAME_DIM);
            end
            we = (int'(sw[7:0]) > SPRITE_W) ? SPRITE_W : int'(sw[7:0]);
            he = (int'(sh[7:0]) > SPRITE_H) ? SPRITE_H : int'(sh[7:0]);
            apply_config(pick_centre(we, fw), pick_centre(he, fh), sw, sh, fw, fh, ph == 5);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            if (we * he <= 48)
            begin
                for (fy = 0; fy < he; fy++)
                    for (fx = 0; fx < we; fx++)
                        load_pixel(12'(fx), 12'(fy), 8'($urandom));
            end
            else
            begin
                repeat (24)
                    load_pixel(12'($urandom_range(we - 1)), 12'($urandom_range(he - 1)),
                               8'($urandom));
            end
            for (i = 0; i < 65; i++)
            begin
                if (i == 32)
                    drain(1);
                r = $urandom_range(99);
                if (r < 10 && we > 0 && he > 0)
                    load_pixel(12'($urandom_range(we - 1)), 12'($urandom_range(he - 1)),
                               8'($urandom));
                else if (r < 14)
                    load_pixel(12'($urandom), 12'($urandom), 8'($urandom));
                else if (r < 60 && window_hits.size() > 0)
                begin
                    idx = window_hits[$urandom_range(window_hits.size() - 1)];
                    send_composite(cur_lx + idx % SPRITE_W, cur_ly + idx / SPRITE_W,
                                   8'($urandom), 8'($urandom), 8'($urandom));
                end
                else if (r < 85)
                    send_composite(cur_lx + int'($urandom_range(cur_w + 3)) - 2,
                                   cur_ly + int'($urandom_range(cur_h + 3)) - 2,
                                   8'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_composite(int'($urandom), int'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        drain(20);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sprite_alpha_overlay_core.f -----
rtl/sao_pkg.sv
rtl/sao_queue.sv
rtl/sao_front.sv
rtl/sao_back.sv
rtl/sprite_alpha_overlay_core.sv
test/sprite_alpha_overlay_checker.sv
test/sprite_alpha_overlay_core_tb.sv
